// ===== sv/string_set_sorter_macros.svh =====
// assertion macros for the string set sorter datapath (ssort_dp)
// expects i_clk and i_rst_n in the scope of use
`ifndef STRING_SET_SORTER_MACROS_SVH
`define STRING_SET_SORTER_MACROS_SVH

// property must hold at every clock edge out of reset
`define SSORT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define SSORT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== sv/ssort_pkg.sv =====
// types, sizes and codes for the string set sorter
// used by ssort_ctrl, ssort_dp and string_set_sorter
package ssort_pkg;

    localparam int MAX_LINES      = 8;
    localparam int MAX_LINE_BYTES = 256;

    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int POS_W  = $clog2(MAX_LINE_BYTES + 1);
    localparam int ADDR_W = $clog2(MAX_LINES * MAX_LINE_BYTES);
    localparam int DEPTH  = MAX_LINES * MAX_LINE_BYTES;
    localparam int IDX_W  = 3;
    localparam int KEY_W  = 9;
    localparam int PADDR_W = 3;

    localparam logic [1:0] MODE_INPUT = 2'd0;
    localparam logic [1:0] MODE_LEX   = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;
    localparam logic [1:0] MODE_WORD  = 2'd3;

    localparam logic REG_SORT_MODE = 1'b0;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_line;
        logic       end_of_set;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] source_index;
        logic [KEY_W-1:0] key_length;
        logic             last_in_run;
    } t_out_word;

    typedef struct packed {
        logic load_en;
        logic pick_start;
        logic cand_inc;
        logic take;
        logic k_clr;
        logic k_inc;
        logic rd_issue;
        logic emit;
        logic clear_set;
    } t_cmd;

    typedef struct packed {
        logic eos_seen;
        logic cand_end;
        logic cand_done;
        logic have_best;
        logic mode_order;
        logic mode_lex;
        logic key_less;
        logic k_end;
        logic byte_ne;
        logic byte_lt;
        logic out_taken;
        logic run_done;
    } t_sts;

endpackage

// ===== sv/ssort_ctrl.sv =====
// sequencer for loading, selection scan, byte compare and result hand-off
// depends on ssort_pkg
module ssort_ctrl import ssort_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD, S_PICK, S_SCAN, S_CMP_RD, S_CMP_CHK, S_EMIT, S_OUT_WAIT
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_en = 1'b1;
                if (i_sts.eos_seen) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick_start = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.cand_end) begin
                    n_state = S_EMIT;
                end else if (i_sts.cand_done) begin
                    o_cmd.cand_inc = 1'b1;
                end else if (!i_sts.have_best) begin
                    o_cmd.take     = 1'b1;
                    o_cmd.cand_inc = 1'b1;
                end else if (i_sts.mode_order) begin
                    o_cmd.cand_inc = 1'b1;
                end else if (i_sts.mode_lex) begin
                    o_cmd.k_clr = 1'b1;
                    n_state = S_CMP_RD;
                end else begin
                    o_cmd.take     = i_sts.key_less;
                    o_cmd.cand_inc = 1'b1;
                end
            end
            S_CMP_RD: begin
                if (i_sts.k_end) begin
                    o_cmd.take     = i_sts.key_less;
                    o_cmd.cand_inc = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.rd_issue = 1'b1;
                    n_state = S_CMP_CHK;
                end
            end
            S_CMP_CHK: begin
                if (i_sts.byte_ne) begin
                    o_cmd.take     = i_sts.byte_lt;
                    o_cmd.cand_inc = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_CMP_RD;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.run_done) begin
                        o_cmd.clear_set = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_PICK;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

// ===== sv/ssort_dp.sv =====
// line store, key lengths, scan registers and output register
// depends on ssort_pkg and string_set_sorter_macros.svh
`include "string_set_sorter_macros.svh"
module ssort_dp import ssort_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_sort_mode,
    input  t_cmd       i_cmd,
    input  logic       i_valid,
    input  t_in_word   i_in_word,
    input  logic       i_stall,
    output logic       o_valid,
    output t_out_word  o_out_word,
    output t_sts       o_sts
);

    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_WORD = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    logic [7:0]        r_store [DEPTH];
    logic [7:0]        r_rd_b, r_rd_c;
    logic [POS_W-1:0]  r_line_len [MAX_LINES];
    logic [POS_W-1:0]  r_word_len [MAX_LINES];
    logic [CNT_W-1:0]  r_line_cnt;
    logic [POS_W-1:0]  r_byte_pos;
    logic [1:0]        r_phase;
    logic [MAX_LINES-1:0] r_emitted;
    logic [LINE_W-1:0] r_best;
    logic [CNT_W-1:0]  r_cand;
    logic [CNT_W-1:0]  r_rank;
    logic [POS_W-1:0]  r_k;
    logic              r_have_best;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic              load;
    logic              blank;
    logic              room_line, room_byte;
    logic [LINE_W-1:0] cur, cand;
    logic [POS_W-1:0]  len_b, len_c, min_len;
    logic [ADDR_W-1:0] wr_addr, rd_addr_b, rd_addr_c;
    logic [POS_W-1:0]  key_b;

    assign load      = i_cmd.load_en && i_valid;
    assign blank     = (i_in_word.char_byte == 8'h20) || (i_in_word.char_byte == 8'h09);
    assign room_line = r_line_cnt < CNT_W'(MAX_LINES);
    assign room_byte = r_byte_pos < POS_W'(MAX_LINE_BYTES);
    assign cur       = r_line_cnt[LINE_W-1:0];
    assign cand      = r_cand[LINE_W-1:0];
    assign len_b     = r_line_len[r_best];
    assign len_c     = r_line_len[cand];
    assign min_len   = (len_b < len_c) ? len_b : len_c;
    assign wr_addr   = ADDR_W'(cur) * ADDR_W'(MAX_LINE_BYTES) + ADDR_W'(r_byte_pos);
    assign rd_addr_b = ADDR_W'(r_best) * ADDR_W'(MAX_LINE_BYTES) + ADDR_W'(r_k);
    assign rd_addr_c = ADDR_W'(cand) * ADDR_W'(MAX_LINE_BYTES) + ADDR_W'(r_k);
    assign key_b     = (i_sort_mode == MODE_WORD) ? r_word_len[r_best] : r_line_len[r_best];

    always_ff @(posedge i_clk) begin
        if (load && room_line && room_byte) begin
            r_store[wr_addr] <= i_in_word.char_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_b <= r_store[rd_addr_b];
            r_rd_c <= r_store[rd_addr_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_set) begin
            for (int i = 0; i < MAX_LINES; i++) begin
                r_line_len[i] <= '0;
                r_word_len[i] <= '0;
            end
            r_line_cnt <= '0;
            r_byte_pos <= '0;
            r_phase    <= PH_SKIP;
            r_emitted  <= '0;
            r_rank     <= '0;
        end else begin
            if (load && room_line) begin
                if (room_byte) begin
                    r_byte_pos      <= r_byte_pos + 1'b1;
                    r_line_len[cur] <= r_byte_pos + 1'b1;
                    if (r_phase == PH_SKIP && !blank) begin
                        r_phase         <= PH_WORD;
                        r_word_len[cur] <= r_word_len[cur] + 1'b1;
                    end else if (r_phase == PH_WORD) begin
                        if (blank) begin
                            r_phase <= PH_DONE;
                        end else begin
                            r_word_len[cur] <= r_word_len[cur] + 1'b1;
                        end
                    end
                end
                if (i_in_word.end_of_line || i_in_word.end_of_set) begin
                    r_line_cnt <= r_line_cnt + 1'b1;
                    r_byte_pos <= '0;
                    r_phase    <= PH_SKIP;
                end
            end
            if (i_cmd.emit) begin
                r_emitted[r_best] <= 1'b1;
                r_rank            <= r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.pick_start) begin
                r_have_best <= 1'b0;
            end else if (i_cmd.take) begin
                r_have_best <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick_start) begin
            r_cand <= '0;
        end else if (i_cmd.cand_inc) begin
            r_cand <= r_cand + 1'b1;
        end
        if (i_cmd.take) begin
            r_best <= cand;
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_word.source_index <= IDX_W'(r_best);
            r_out_word.key_length   <= KEY_W'(key_b);
            r_out_word.last_in_run  <= (r_rank + 1'b1) == r_line_cnt;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.eos_seen   = i_valid && i_in_word.end_of_set;
        o_sts.cand_end   = r_cand == r_line_cnt;
        o_sts.cand_done  = r_emitted[cand];
        o_sts.have_best  = r_have_best;
        o_sts.mode_order = i_sort_mode == MODE_INPUT;
        o_sts.mode_lex   = i_sort_mode == MODE_LEX;
        o_sts.key_less   = (i_sort_mode == MODE_WORD) ? (r_word_len[cand] < r_word_len[r_best])
                                                      : (len_c < len_b);
        o_sts.k_end      = r_k == min_len;
        o_sts.byte_ne    = r_rd_c != r_rd_b;
        o_sts.byte_lt    = r_rd_c < r_rd_b;
        o_sts.out_taken  = r_out_valid && !i_stall;
        o_sts.run_done   = r_rank == r_line_cnt;
    end

    assign o_valid    = r_out_valid;
    assign o_out_word = r_out_word;

    `SSORT_ASSERT(a_emit_has_best, i_cmd.emit |-> r_have_best, "emit without a chosen line")
    `SSORT_ASSERT(a_emit_fresh, i_cmd.emit |-> !r_emitted[r_best], "line emitted twice")
    `SSORT_NEVER(a_cnt_range, r_line_cnt > CNT_W'(MAX_LINES), "line count past limit")

endmodule

// ===== sv/string_set_sorter.sv =====
// Loads up to 8 lines one byte word per cycle while o_stall is low. The word that carries
// end_of_set closes the set; input then stalls while a selection sort emits one word per
// line in ascending key order (input order in MODE_INPUT), ties in input order. Each rank
// runs one scan over all n lines plus the pick, end check, emit and hand-off states. In
// lexicographic mode each compare passes through S_CMP_RD and S_CMP_CHK for every byte
// read from the line store, and through S_CMP_RD once more when the shorter line runs
// out; a waiting output word holds the sequencer until it is taken.
// Depends on ssort_pkg, ssort_ctrl and ssort_dp.
module string_set_sorter import ssort_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_in_word           i_in_word,
    output logic               o_stall,
    output logic               o_valid,
    output t_out_word          o_out_word,
    input  logic               i_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [1:0] r_sort_mode;
    t_cmd       cmd;
    t_sts       sts;
    logic       reg_sel;

    assign reg_sel = paddr[PADDR_W-1];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_mode <= MODE_LEX;
        end else if (psel && penable && pwrite && reg_sel == REG_SORT_MODE) begin
            r_sort_mode <= pwdata[1:0];
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SORT_MODE: prdata = {30'd0, r_sort_mode};
            default:       prdata = '0;
        endcase
    end

    ssort_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ssort_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sort_mode (r_sort_mode),
        .i_cmd       (cmd),
        .i_valid     (i_valid),
        .i_in_word   (i_in_word),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_word  (o_out_word),
        .o_sts       (sts)
    );

    assign o_stall = !cmd.load_en;

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for string_set_sorter: drives line bytes, predicts sorted ranks
// depends on ssort_pkg and the string_set_sorter rtl
`timescale 1ns / 100ps

module testbench import ssort_pkg::*; ();

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    t_in_word           i_in_word;
    logic               o_stall;
    logic               o_valid;
    t_out_word          o_out_word;
    logic               i_stall;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    string_set_sorter DUT (.*);

    t_in_word  pending_words[$];
    t_out_word expected_ranks[$];

    logic [7:0] line_bytes[MAX_LINES][MAX_LINE_BYTES];
    int         line_len[MAX_LINES];
    int         word_len[MAX_LINES];
    int         lines_held;
    int         byte_pos;
    int         word_state;
    logic [1:0] mode_now;

    int errors;
    int words_in;
    int words_out;
    int sets_done;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    logic cfg_busy;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic bit key_precedes(input int a, input int b);
        int n;
        if (mode_now == MODE_LINE) begin
            return line_len[a] < line_len[b];
        end
        if (mode_now == MODE_WORD) begin
            return word_len[a] < word_len[b];
        end
        n = line_len[a] < line_len[b] ? line_len[a] : line_len[b];
        for (int k = 0; k < n; k++) begin
            if (line_bytes[a][k] != line_bytes[b][k]) begin
                return line_bytes[a][k] < line_bytes[b][k];
            end
        end
        return line_len[a] < line_len[b];
    endfunction

    task automatic predict_ranks(input t_in_word w);
        int order[MAX_LINES];
        int x;
        int j;
        t_out_word r;
        bit blank;
        blank = (w.char_byte == 8'h20) || (w.char_byte == 8'h09);
        if (lines_held < MAX_LINES) begin
            if (byte_pos < MAX_LINE_BYTES) begin
                line_bytes[lines_held][byte_pos] = w.char_byte;
                byte_pos++;
                line_len[lines_held] = byte_pos;
                if (word_state == 0) begin
                    if (!blank) begin
                        word_state = 1;
                        word_len[lines_held]++;
                    end
                end else if (word_state == 1) begin
                    if (blank) word_state = 2;
                    else word_len[lines_held]++;
                end
            end
            if (w.end_of_line || w.end_of_set) begin
                lines_held++;
                byte_pos = 0;
                word_state = 0;
            end
        end
        if (!w.end_of_set) return;
        for (int i = 0; i < lines_held; i++) order[i] = i;
        if (mode_now != MODE_INPUT) begin
            for (int i = 1; i < lines_held; i++) begin
                x = order[i];
                j = i;
                while (j > 0 && key_precedes(x, order[j-1])) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = x;
            end
        end
        for (int i = 0; i < lines_held; i++) begin
            r.source_index = order[i][IDX_W-1:0];
            r.key_length   = (mode_now == MODE_WORD) ? word_len[order[i]][KEY_W-1:0]
                                                     : line_len[order[i]][KEY_W-1:0];
            r.last_in_run  = (i + 1 == lines_held);
            expected_ranks.push_back(r);
        end
        for (int i = 0; i < MAX_LINES; i++) begin
            line_len[i] = 0;
            word_len[i] = 0;
        end
        lines_held = 0;
        byte_pos = 0;
        word_state = 0;
        sets_done++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_ranks(i_in_word);
                words_in++;
            end
            if ((i_valid && !o_stall) || !i_valid) begin
                if (pending_words.size() > 0 && !cfg_busy
                    && $urandom_range(99) >= send_idle_pct) begin
                    i_in_word <= pending_words.pop_front();
                    i_valid   <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                words_out++;
                if (expected_ranks.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    want = expected_ranks.pop_front();
                    if (o_out_word.source_index != want.source_index)
                        report_mismatch("source_index", o_out_word.source_index,
                                        want.source_index);
                    if (o_out_word.key_length != want.key_length)
                        report_mismatch("key_length", o_out_word.key_length,
                                        want.key_length);
                    if (o_out_word.last_in_run != want.last_in_run)
                        report_mismatch("last_in_run", o_out_word.last_in_run,
                                        want.last_in_run);
                end
            end
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    task automatic write_mode(input logic [1:0] m);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= PADDR_W'(4 * REG_SORT_MODE);
        pwdata  <= 32'(m);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_now = m;
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || i_valid || expected_ranks.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic push_line(input string s, input bit last);
        t_in_word w;
        for (int k = 0; k < s.len(); k++) begin
            w.char_byte   = s[k];
            w.end_of_line = (k == s.len() - 1);
            w.end_of_set  = last && (k == s.len() - 1);
            pending_words.push_back(w);
        end
    endtask

    function automatic logic [7:0] rand_byte(input int flavor);
        case (flavor)
            0: return ($urandom_range(1) != 0) ? 8'h20 : 8'h09;
            1: return 8'(8'h61 + $urandom_range(2));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic push_random_set(input int lines, input int maxlen);
        t_in_word w;
        int len;
        int flavor;
        flavor = $urandom_range(2);
        for (int l = 0; l < lines; l++) begin
            len = $urandom_range(maxlen, 1);
            for (int k = 0; k < len; k++) begin
                w.char_byte = ($urandom_range(3) == 0) ? rand_byte(0) : rand_byte(flavor);
                w.end_of_line = (k == len - 1) || ($urandom_range(40) == 0);
                w.end_of_set  = (l == lines - 1) && (k == len - 1);
                pending_words.push_back(w);
            end
        end
    endtask

    task automatic run_phase(input logic [1:0] m, input int items);
        int start;
        write_mode(m);
        start = pending_words.size();
        while (pending_words.size() - start < items)
            push_random_set($urandom_range(MAX_LINES + 2, 1), $urandom_range(1) ? 4 : 3);
        wait_drained();
    endtask

    initial begin
        t_in_word w;
        errors = 0; words_in = 0; words_out = 0; sets_done = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0; cfg_busy = 1'b0;
        i_valid = 1'b0; i_in_word = '0; i_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int i = 0; i < MAX_LINES; i++) begin
            line_len[i] = 0;
            word_len[i] = 0;
        end
        lines_held = 0; byte_pos = 0; word_state = 0; mode_now = MODE_LEX;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lexicographic at reset value, blanks, nul, extreme bytes
        push_line("  ab\tc", 1'b0);
        push_line("ab", 1'b0);
        w.char_byte = 8'h00; w.end_of_line = 1'b0; w.end_of_set = 1'b0;
        pending_words.push_back(w);
        w.char_byte = 8'hff; w.end_of_line = 1'b1; w.end_of_set = 1'b1;
        pending_words.push_back(w);
        wait_drained();
        // long line, then overflow of line count
        write_mode(MODE_LINE);
        for (int k = 0; k < MAX_LINE_BYTES + 3; k++) begin
            w.char_byte = 8'($urandom_range(255));
            w.end_of_line = (k == MAX_LINE_BYTES + 2);
            w.end_of_set = 1'b0;
            pending_words.push_back(w);
        end
        for (int l = 0; l < MAX_LINES + 1; l++) push_line("x y", 1'b0);
        w.char_byte = 8'h7a; w.end_of_line = 1'b1; w.end_of_set = 1'b1;
        pending_words.push_back(w);
        wait_drained();
        write_mode(MODE_WORD);
        push_line(" \t", 1'b0);
        push_line("\tabc de", 1'b0);
        push_line("q", 1'b1);
        wait_drained();
        write_mode(MODE_INPUT);
        push_line("zz", 1'b0);
        push_line("a", 1'b1);
        wait_drained();

        // random phases with varying idle and stall
        run_phase(MODE_LEX, 6);
        send_idle_pct = 53;
        run_phase(MODE_WORD, 6);
        send_idle_pct = 0; recv_stall_pct = 53;
        run_phase(MODE_LINE, 6);
        send_idle_pct = 10; recv_stall_pct = 10;
        run_phase(MODE_INPUT, 6);
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_cycles = 400;
        run_phase(MODE_LEX, 6);
        send_idle_pct = 53; recv_stall_pct = 53;
        run_phase(MODE_WORD, 6);
        send_idle_pct = 20; recv_stall_pct = 30;
        run_phase(MODE_LEX, 6);

        $display("ran %0d input words and %0d sorted words over %0d sets",
                 words_in, words_out, sets_done);
        $display("all four sort modes, long lines, line overflow and stalls covered");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
